[rtl/qte_pkg.sv]
`default_nettype none

package qte_pkg;

    localparam int QUAT_BITS      = 16;
    localparam int QUAT_FRAC_BITS = 15;
    localparam int ANGLE_BITS     = 16;

    // products, sums and atan2 operands
    localparam int PROD_W = 2 * QUAT_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W;

    // pitch magnitude in Q30, its square and the radicand
    localparam int MS_W      = 31;
    localparam int MS_SHIFT  = 2 * QUAT_FRAC_BITS - 30;
    localparam int MSQ_W     = 2 * MS_W;
    localparam int RAD_TOP   = 60;
    localparam int RAD_W     = RAD_TOP + 1;
    localparam int ROOT_W    = RAD_W + 1;
    localparam int ISQ_STEPS = RAD_TOP / 2 + 1;

    // normalizer and cordic datapath
    localparam int NORM_STEPS = 6;
    localparam int NORM_W     = 30;
    localparam int CORD_W     = 34;
    localparam int Z_W        = 33;
    localparam int ROUND_SH   = 32 - ANGLE_BITS;

    typedef logic signed [QUAT_BITS-1:0] t_qval;

    typedef struct packed {
        t_qval quat_w;
        t_qval quat_x;
        t_qval quat_y;
        t_qval quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_euler;

    // quadrant and special-case flags that ride along with an atan2
    typedef struct packed {
        logic num_neg;
        logic den_neg;
        logic ay_zero;
        logic ax_zero;
    } t_quad;

    // atan(2^-i) with 2^31 standing for pi
    function automatic logic [31:0] atan_entry(input int unsigned idx);
        logic [31:0] v;
        case (idx[4:0])
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            5'd31:   v = 32'd0;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/qte_atan.sv]
`default_nettype none

module qte_atan import qte_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic signed [SUM_W-1:0]      i_num,
    input  logic signed [SUM_W-1:0]      i_den,
    output logic signed [ANGLE_BITS-1:0] o_angle
);

    localparam logic signed [Z_W-1:0] QUARTER = Z_W'(2**30);
    localparam logic signed [Z_W-1:0] HALF    = Z_W'(2**(ROUND_SH-1));
    localparam logic [ANGLE_BITS-1:0] PI      = ANGLE_BITS'(1) << (ANGLE_BITS-1);

    logic [MAG_W-1:0] r_ax [NORM_STEPS+1];
    logic [MAG_W-1:0] r_ay [NORM_STEPS+1];
    t_quad            r_nq [NORM_STEPS+1];

    logic signed [CORD_W-1:0] r_x [CORDIC_STAGES];
    logic signed [CORD_W-1:0] r_y [CORDIC_STAGES];
    logic signed [Z_W-1:0]    r_z [CORDIC_STAGES];
    t_quad                    r_cq [CORDIC_STAGES];

    logic signed [CORD_W-1:0] w_x0;
    logic signed [CORD_W-1:0] w_y0;

    logic signed [Z_W-1:0]    w_zc;
    logic signed [Z_W-1:0]    w_zr;
    logic [ANGLE_BITS-1:0]    n_a;
    logic [ANGLE_BITS-1:0]    r_a;
    t_quad                    r_fq;
    logic [ANGLE_BITS-1:0]    n_angle;
    logic [ANGLE_BITS-1:0]    r_angle;

    // magnitudes and flags
    always_ff @(posedge i_clk) begin
        r_ax[0] <= i_den[SUM_W-1] ? MAG_W'(-i_den) : MAG_W'(i_den);
        r_ay[0] <= i_num[SUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
        r_nq[0] <= '{num_neg: i_num[SUM_W-1], den_neg: i_den[SUM_W-1],
                     ay_zero: (i_num == '0), ax_zero: (i_den == '0)};
    end

    // shift both left together until the larger one reaches the top bit
    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        localparam int K = 1 << (NORM_STEPS - 1 - g);
        logic [MAG_W-1:0] w_or;
        assign w_or = r_ax[g] | r_ay[g];
        always_ff @(posedge i_clk) begin
            if (w_or[MAG_W-1 -: K] == '0) begin
                r_ax[g+1] <= r_ax[g] << K;
                r_ay[g+1] <= r_ay[g] << K;
            end else begin
                r_ax[g+1] <= r_ax[g];
                r_ay[g+1] <= r_ay[g];
            end
            r_nq[g+1] <= r_nq[g];
        end
    end

    // top bits land the larger operand in [2^29, 2^30)
    assign w_x0 = CORD_W'(r_ax[NORM_STEPS][MAG_W-1 -: NORM_W]);
    assign w_y0 = CORD_W'(r_ay[NORM_STEPS][MAG_W-1 -: NORM_W]);

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_entry(i));
        logic signed [CORD_W-1:0] w_xi;
        logic signed [CORD_W-1:0] w_yi;
        logic signed [Z_W-1:0]    w_zi;
        t_quad                    w_qi;
        if (i == 0) begin : g_first
            assign w_xi = w_x0;
            assign w_yi = w_y0;
            assign w_zi = '0;
            assign w_qi = r_nq[NORM_STEPS];
        end else begin : g_next
            assign w_xi = r_x[i-1];
            assign w_yi = r_y[i-1];
            assign w_zi = r_z[i-1];
            assign w_qi = r_cq[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!w_yi[CORD_W-1]) begin
                r_x[i] <= w_xi + (w_yi >>> i);
                r_y[i] <= w_yi - (w_xi >>> i);
                r_z[i] <= w_zi + ANG;
            end else begin
                r_x[i] <= w_xi - (w_yi >>> i);
                r_y[i] <= w_yi + (w_xi >>> i);
                r_z[i] <= w_zi - ANG;
            end
            r_cq[i] <= w_qi;
        end
    end

    // clamp to the first quadrant and round half up
    always_comb begin
        if (r_z[CORDIC_STAGES-1] < 0) begin
            w_zc = '0;
        end else if (r_z[CORDIC_STAGES-1] > QUARTER) begin
            w_zc = QUARTER;
        end else begin
            w_zc = r_z[CORDIC_STAGES-1];
        end
        if (r_cq[CORDIC_STAGES-1].ax_zero) begin
            w_zc = QUARTER;
        end
        w_zr = w_zc + HALF;
        n_a  = ANGLE_BITS'(w_zr >>> ROUND_SH);
        if (r_cq[CORDIC_STAGES-1].ay_zero) begin
            n_a = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_fq <= r_cq[CORDIC_STAGES-1];
    end

    // unfold to the full circle, wrapping modulo the angle width
    always_comb begin
        if (!r_fq.den_neg) begin
            n_angle = r_fq.num_neg ? -r_a : r_a;
        end else begin
            n_angle = r_fq.num_neg ? r_a - PI : PI - r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    assign o_angle = $signed(r_angle);

endmodule

`default_nettype wire

[rtl/quaternion_to_euler_angles.sv]
`default_nettype none

// quaternion to zyx euler angles (roll, pitch, yaw), fully pipelined
//
// a transaction is accepted at each rising edge with start high; busy is
// always low, so a new quaternion may enter on every cycle
// i_quat carries w, x, y, z as signed q1.15; o_result carries roll, pitch
// and yaw as signed binary angles with 32768 standing for pi
// each result appears on o_result for one cycle with o_valid high, in
// order of acceptance; throughput is one result per cycle
// pipeline: 4 stages of products, sums, pitch squaring and the radicand,
// 31 stages of the pitch square root (one root bit per stage), then per
// angle 1 magnitude stage, 6 normalizer stages, CORDIC_STAGES vectoring
// stages and 2 stages of rounding and quadrant unfolding
// synchronous reset clears the valid pipeline, dropping items in flight;
// the receiver cannot stall, results are presented whether taken or not
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_quat  i_quat,
    output logic   o_valid,
    output t_euler o_result
);

    localparam int ATAN_LAT = NORM_STEPS + CORDIC_STAGES + 3;
    localparam int LAT      = 4 + ISQ_STEPS + ATAN_LAT;
    localparam int DLY      = 2 + ISQ_STEPS;

    localparam logic signed [SUM_W-1:0] ONE     = SUM_W'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam logic [MSQ_W-1:0]        RAD_ONE = MSQ_W'(1) << RAD_TOP;

    logic [LAT-1:0] r_vld;

    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;

    logic signed [SUM_W-1:0] n_s;
    logic signed [SUM_W-1:0] w_sc;
    logic [SUM_W-1:0]        w_sabs;

    logic signed [SUM_W-1:0] r_d_rnum [DLY+1];
    logic signed [SUM_W-1:0] r_d_rden [DLY+1];
    logic signed [SUM_W-1:0] r_d_ynum [DLY+1];
    logic signed [SUM_W-1:0] r_d_yden [DLY+1];
    logic [MS_W-1:0]         r_d_ms   [DLY+1];
    logic                    r_d_sneg [DLY+1];

    logic [MSQ_W-1:0]  r_msq;
    logic [RAD_W-1:0]  r_rad;
    logic [RAD_W-1:0]  r_rn [ISQ_STEPS-1];
    logic [ROOT_W-1:0] r_rs [ISQ_STEPS];

    logic signed [SUM_W-1:0]      w_pnum;
    logic signed [SUM_W-1:0]      w_pden;
    logic signed [ANGLE_BITS-1:0] w_roll, w_pitch, w_yaw;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx <= i_quat.quat_w * i_quat.quat_x;
        r_yz <= i_quat.quat_y * i_quat.quat_z;
        r_xx <= i_quat.quat_x * i_quat.quat_x;
        r_yy <= i_quat.quat_y * i_quat.quat_y;
        r_wz <= i_quat.quat_w * i_quat.quat_z;
        r_xy <= i_quat.quat_x * i_quat.quat_y;
        r_zz <= i_quat.quat_z * i_quat.quat_z;
        r_wy <= i_quat.quat_w * i_quat.quat_y;
        r_zx <= i_quat.quat_z * i_quat.quat_x;
    end

    // pitch sine, saturated to +-1 for non-unit quaternions
    always_comb begin
        n_s = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
        if (n_s > ONE) begin
            w_sc = ONE;
        end else if (n_s < -ONE) begin
            w_sc = -ONE;
        end else begin
            w_sc = n_s;
        end
        w_sabs = w_sc[SUM_W-1] ? SUM_W'(-w_sc) : SUM_W'(w_sc);
    end

    always_ff @(posedge i_clk) begin
        r_d_rnum[0] <= (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        r_d_rden[0] <= ONE - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        r_d_ynum[0] <= (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        r_d_yden[0] <= ONE - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        r_d_ms[0]   <= MS_W'(w_sabs >> MS_SHIFT);
        r_d_sneg[0] <= w_sc[SUM_W-1];
    end

    // operands wait here while the pitch cosine is worked out
    for (genvar k = 0; k < DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_d_rnum[k+1] <= r_d_rnum[k];
            r_d_rden[k+1] <= r_d_rden[k];
            r_d_ynum[k+1] <= r_d_ynum[k];
            r_d_yden[k+1] <= r_d_yden[k];
            r_d_ms[k+1]   <= r_d_ms[k];
            r_d_sneg[k+1] <= r_d_sneg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_msq <= MSQ_W'(r_d_ms[0]) * MSQ_W'(r_d_ms[0]);
        r_rad <= RAD_W'(RAD_ONE - r_msq);
    end

    // floor square root, one result bit per stage
    for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isqrt
        localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (RAD_TOP - 2 * j);
        logic [RAD_W-1:0]  w_n;
        logic [ROOT_W-1:0] w_res;
        logic [ROOT_W-1:0] w_t;
        logic              w_ge;
        if (j == 0) begin : g_first
            assign w_n   = r_rad;
            assign w_res = '0;
        end else begin : g_next
            assign w_n   = r_rn[j-1];
            assign w_res = r_rs[j-1];
        end
        assign w_t  = w_res + BIT;
        assign w_ge = ({1'b0, w_n} >= w_t);
        always_ff @(posedge i_clk) begin
            r_rs[j] <= w_ge ? (w_res >> 1) + BIT : w_res >> 1;
        end
        if (j < ISQ_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rn[j] <= w_ge ? RAD_W'({1'b0, w_n} - w_t) : w_n;
            end
        end
    end

    assign w_pnum = r_d_sneg[DLY] ? -SUM_W'(r_d_ms[DLY]) : SUM_W'(r_d_ms[DLY]);
    assign w_pden = SUM_W'(r_rs[ISQ_STEPS-1]);

    qte_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_num   (r_d_rnum[DLY]),
        .i_den   (r_d_rden[DLY]),
        .o_angle (w_roll)
    );

    qte_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_num   (w_pnum),
        .i_den   (w_pden),
        .o_angle (w_pitch)
    );

    qte_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_num   (r_d_ynum[DLY]),
        .i_den   (r_d_yden[DLY]),
        .o_angle (w_yaw)
    );

    assign o_valid              = r_vld[LAT-1];
    assign o_result.roll_angle  = 16'(w_roll);
    assign o_result.pitch_angle = 16'(w_pitch);
    assign o_result.yaw_angle   = 16'(w_yaw);

endmodule

`default_nettype wire

[rtl/qte_checker.sv]
`default_nettype none

module qte_checker import qte_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   start,
    input logic   busy,
    input logic   o_valid,
    input t_euler o_result
);

    localparam int LAT = 4 + ISQ_STEPS + NORM_STEPS + CORDIC_STAGES + 3;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("transaction lost or late");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a transaction");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_result.pitch_angle) >= -16'sd16384 &&
                     $signed(o_result.pitch_angle) <= 16'sd16384))
        else $error("pitch beyond half pi");

endmodule

bind quaternion_to_euler_angles qte_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_qte_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
